FILE: design/assert_macros.svh
// Assertion helpers for the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/plsub_pkg.sv
package plsub_pkg;
  localparam int COORD_BITS = 24;
  localparam int CFG_BITS   = 24;
  localparam int MAX_PIECES = 64;
  localparam int N_BITS     = $clog2(MAX_PIECES + 1);
  localparam int D_BITS     = COORD_BITS + 1;
  // Even width so that the root takes the radicand in aligned bit pairs.
  localparam int SQ_BITS    = 2 * D_BITS;
  localparam int LEN_BITS   = (SQ_BITS + 1) / 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [D_BITS-1:0]     delta_t;

  // Word handed from the front part to the back part.
  typedef struct packed {
    logic   single;
    coord_t px;
    coord_t py;
    coord_t cx;
    coord_t cy;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE, BK_SQRT, BK_DIV, BK_EMIT
  } bk_state_t;
endpackage

FILE: design/plsub_if.sv
interface plsub_in_if import plsub_pkg::*; (input logic clk);
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   line_start;
  modport source (output valid, point_x, point_y, line_start, input ready);
  modport sink (input valid, point_x, point_y, line_start, output ready);
endinterface

interface plsub_out_if import plsub_pkg::*; (input logic clk);
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  logic   is_inserted;
  logic   run_last;
  modport source (output valid, out_x, out_y, is_inserted, run_last, input ready);
  modport sink (input valid, out_x, out_y, is_inserted, run_last, output ready);
endinterface

FILE: design/plsub_front.sv
module plsub_front import plsub_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  plsub_in_if.sink        in_ch,
  output logic            job_valid,
  input  logic            job_ready,
  output job_t            job
);
  coord_t prev_x_r, prev_y_r;
  logic   have_prev_r;
  logic   take;

  assign in_ch.ready = job_ready;
  assign job_valid   = in_ch.valid;
  assign take        = in_ch.valid && job_ready;

  always_comb begin
    job.single = in_ch.line_start || !have_prev_r;
    job.px     = prev_x_r;
    job.py     = prev_y_r;
    job.cx     = in_ch.point_x;
    job.cy     = in_ch.point_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
    end else if (take) begin
      have_prev_r <= 1'b1;
      prev_x_r    <= in_ch.point_x;
      prev_y_r    <= in_ch.point_y;
    end
  end
endmodule

FILE: design/plsub_queue.sv
module plsub_queue import plsub_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);
  job_t                mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wp_r, rp_r;
  logic [QPTR_BITS:0]   cnt_r;
  logic                 wr, rd;

  assign wr_ready = (cnt_r != (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_BITS+1)'(wr) - (QPTR_BITS+1)'(rd);
    end
  end
endmodule

FILE: design/plsub_back.sv
module plsub_back import plsub_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CFG_BITS-1:0] seg_max,
  input  logic              job_valid,
  output logic              job_ready,
  input  job_t              job,
  plsub_out_if.source       out_ch
);
  bk_state_t state_r, state_nxt;
  job_t      job_r;
  delta_t    dx_r, dy_r;
  logic [SQ_BITS-1:0]  rem_r;        // square-root remainder
  logic [SQ_BITS-1:0]  rad_r;
  logic [LEN_BITS-1:0] root_r;
  logic [5:0]          it_r;         // shared iteration counter
  logic [LEN_BITS-1:0] qrem_r;
  logic [LEN_BITS-1:0] quo_r;
  logic [N_BITS-1:0]   n_r, i_r;
  // Interpolation: dx*i/n via restoring division of |dx*i| by n.
  logic [D_BITS+N_BITS-1:0] mx_r, my_r;
  logic [D_BITS+N_BITS-1:0] rx_r, ry_r, qx_r, qy_r;
  logic [5:0]          step_r;
  logic                ovalid_r;
  coord_t              ox_r, oy_r;
  logic                oins_r, olast_r;
  logic [D_BITS-1:0]   adx, ady;
  logic [2*D_BITS-1:0] sq;
  logic [SQ_BITS+1:0]  trial;
  logic [LEN_BITS:0]   dtrial;
  logic [D_BITS+N_BITS:0] tx, ty;
  logic                out_free;
  logic                load_mul;

  localparam int DIV_W = D_BITS + N_BITS;

  assign out_free   = !ovalid_r || out_ch.ready;
  assign job_ready  = (state_r == BK_IDLE) && out_free;
  assign out_ch.valid       = ovalid_r;
  assign out_ch.out_x       = ox_r;
  assign out_ch.out_y       = oy_r;
  assign out_ch.is_inserted = oins_r;
  assign out_ch.run_last    = olast_r;

  assign adx = dx_r[D_BITS-1] ? D_BITS'(-dx_r) : D_BITS'(dx_r);
  assign ady = dy_r[D_BITS-1] ? D_BITS'(-dy_r) : D_BITS'(dy_r);
  assign sq  = (it_r[0]) ? ady * ady : adx * adx;

  // One root bit per cycle: trial = (rem<<2 | next two bits) - (root<<2 | 1).
  assign trial  = {rem_r, rad_r[SQ_BITS-1 -: 2]} -
                  (SQ_BITS+2)'({root_r, 2'b01});
  assign dtrial = {qrem_r, root_r[LEN_BITS-1]} - (LEN_BITS+1)'(seg_max);
  assign tx = {rx_r, mx_r[DIV_W-1]} - (DIV_W+1)'(n_r);
  assign ty = {ry_r, my_r[DIV_W-1]} - (DIV_W+1)'(n_r);

  always_comb begin
    state_nxt = state_r;
    load_mul  = 1'b0;
    unique case (state_r)
      BK_IDLE: if (job_valid && job_ready && !job.single) state_nxt = BK_SQRT;
      BK_SQRT: if (it_r == 6'd1 + 6'(LEN_BITS)) state_nxt = BK_DIV;
      BK_DIV:  if (it_r == 6'(LEN_BITS - 1)) state_nxt = BK_EMIT;
      BK_EMIT: if (out_free && step_r == 6'(DIV_W) && i_r == n_r) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
    load_mul = (state_r == BK_DIV) && (it_r == 6'(LEN_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      if (out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        BK_IDLE: begin
          if (job_valid && job_ready) begin
            job_r <= job;
            dx_r  <= D_BITS'(job.cx) - D_BITS'(job.px);
            dy_r  <= D_BITS'(job.cy) - D_BITS'(job.py);
            it_r  <= '0;
            root_r <= '0;
            rem_r  <= '0;
            rad_r  <= '0;
            if (job.single) begin
              ovalid_r <= 1'b1;
              ox_r <= job.cx; oy_r <= job.cy;
              oins_r <= 1'b0; olast_r <= 1'b1;
            end
          end
        end
        BK_SQRT: begin
          // Forms dx*dx, then adds dy*dy, then one root bit a cycle.
          it_r <= it_r + 6'd1;
          if (it_r == 6'd0) begin
            rad_r <= SQ_BITS'(sq);
          end else if (it_r == 6'd1) begin
            rad_r <= rad_r + SQ_BITS'(sq);
          end else begin
            rad_r <= {rad_r[SQ_BITS-3:0], 2'b00};
            if (!trial[SQ_BITS+1]) begin
              rem_r  <= SQ_BITS'(trial);
              root_r <= {root_r[LEN_BITS-2:0], 1'b1};
            end else begin
              rem_r  <= {rem_r[SQ_BITS-3:0], rad_r[SQ_BITS-1 -: 2]};
              root_r <= {root_r[LEN_BITS-2:0], 1'b0};
            end
          end
          if (it_r == 6'd1 + 6'(LEN_BITS)) begin
            it_r   <= '0;
            qrem_r <= '0;
            quo_r  <= '0;
          end
        end
        BK_DIV: begin
          // Restoring division of the length by the limit, one bit a cycle.
          it_r   <= it_r + 6'd1;
          root_r <= {root_r[LEN_BITS-2:0], 1'b0};
          if (!dtrial[LEN_BITS]) begin
            qrem_r <= LEN_BITS'(dtrial);
            quo_r  <= {quo_r[LEN_BITS-2:0], 1'b1};
          end else begin
            qrem_r <= {qrem_r[LEN_BITS-2:0], root_r[LEN_BITS-1]};
            quo_r  <= {quo_r[LEN_BITS-2:0], 1'b0};
          end
          if (load_mul) begin
            i_r    <= N_BITS'(1);
            step_r <= '0;
            rx_r   <= '0; ry_r <= '0;
            mx_r   <= DIV_W'(adx);
            my_r   <= DIV_W'(ady);
          end
        end
        BK_EMIT: begin
          if (step_r < 6'(DIV_W)) begin
            step_r <= step_r + 6'd1;
            mx_r <= {mx_r[DIV_W-2:0], !tx[DIV_W]};
            my_r <= {my_r[DIV_W-2:0], !ty[DIV_W]};
            rx_r <= tx[DIV_W] ? {rx_r[DIV_W-2:0], mx_r[DIV_W-1]} : DIV_W'(tx);
            ry_r <= ty[DIV_W] ? {ry_r[DIV_W-2:0], my_r[DIV_W-1]} : DIV_W'(ty);
          end else if (out_free) begin
            ovalid_r <= 1'b1;
            if (i_r == n_r) begin
              ox_r <= job_r.cx; oy_r <= job_r.cy;
              oins_r <= 1'b0; olast_r <= 1'b1;
            end else begin
              ox_r <= COORD_BITS'(D_BITS'(job_r.px) +
                      (dx_r[D_BITS-1] ? -D_BITS'(mx_r) : D_BITS'(mx_r)));
              oy_r <= COORD_BITS'(D_BITS'(job_r.py) +
                      (dy_r[D_BITS-1] ? -D_BITS'(my_r) : D_BITS'(my_r)));
              oins_r <= 1'b1; olast_r <= 1'b0;
              i_r    <= i_r + N_BITS'(1);
              step_r <= '0;
              rx_r <= '0; ry_r <= '0;
              mx_r <= DIV_W'(adx) * DIV_W'(i_r + N_BITS'(1));
              my_r <= DIV_W'(ady) * DIV_W'(i_r + N_BITS'(1));
            end
          end
        end
        default: ;
      endcase
    end
  end

  // n from the quotient; a zero limit forces the maximum.
  always_ff @(posedge clk) begin
    if (load_mul) begin
      if (seg_max == '0 ||
          {quo_r[LEN_BITS-2:0], !dtrial[LEN_BITS]} >= LEN_BITS'(MAX_PIECES - 1))
        n_r <= N_BITS'(MAX_PIECES);
      else
        n_r <= N_BITS'({quo_r[LEN_BITS-2:0], !dtrial[LEN_BITS]}) + N_BITS'(1);
    end
  end
endmodule

FILE: design/polyline_subdivide.sv
// Timing: a line-start vertex (or the first after reset) passes through the job queue and
// the output register; any other vertex first gets its length from a serial square root
// and divides it by the limit, then each word comes from the serial interpolation divider.
// The back part takes one vertex at a time: no new vertex until its last word is issued.
// Reset: synchronous active-low rst_n clears control, limit returns to 256.
`include "assert_macros.svh"
module polyline_subdivide import plsub_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  plsub_in_if.sink            in_ch,
  plsub_out_if.source         out_ch
);
  logic [CFG_BITS-1:0] seg_max_r;
  logic fq_valid, fq_ready, bq_valid, bq_ready;
  job_t fq_job, bq_job;

  always_ff @(posedge clk) begin
    if (!rst_n)      seg_max_r <= CFG_BITS'(256);
    else if (cfg_we) seg_max_r <= cfg_wdata;
  end

  plsub_front u_front (
    .clk, .rst_n, .in_ch,
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  plsub_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_job)
  );

  plsub_back u_back (
    .clk, .rst_n, .seg_max(seg_max_r),
    .job_valid(bq_valid), .job_ready(bq_ready), .job(bq_job), .out_ch
  );

  `ASSERT_IMPL(a_last_not_inserted, clk, rst_n, out_ch.valid && out_ch.run_last,
    !out_ch.is_inserted, "last word marked inserted")
  `ASSERT_IMPL(a_ins_not_last, clk, rst_n, out_ch.valid && out_ch.is_inserted,
    !out_ch.run_last, "inserted word marked last")
  `ASSERT_NEXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(out_ch.out_x), "stalled word changed")
endmodule
